[rtl/ffa_pkg.sv]
// shared types and codes for the first-fit allocator
package ffa_pkg;

  localparam int ReqW = 21;
  localparam int OffW = 20;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TAG_PTR  = 2'd0,
    TAG_NULL = 2'd1,
    TAG_USED = 2'd2
  } link_tag_t;

  localparam logic OP_ALLOC = 1'b0;

  typedef struct packed {
    logic load;
    logic setup;
    logic rd_cur;
    logic step;
    logic wr_tail;
    logic wr_prev;
    logic wr_mark;
    logic rd_free;
    logic wr_free;
    logic out_load;
    logic out_ofs;
  } ffa_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic req_zero;
    logic heap_ready;
    logic cur_null;
    logic fits;
    logic split;
    logic free_null;
    logic free_bad;
    logic free_used;
  } ffa_stat_t;

endpackage

[rtl/ffa_datapath.sv]
// header memory, list pointers and arithmetic of the allocator
module ffa_datapath import ffa_pkg::*; #(
  parameter int HEAP_BYTES   = 1048576,
  parameter int HEADER_BYTES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  ffa_cmd_t        cmd,
  output ffa_stat_t       stat,
  input  logic [47:0]     in_data,
  output logic [OffW-1:0] result_offset
);

  localparam int AW = (HEAP_BYTES > 1) ? $clog2(HEAP_BYTES) : 1;
  localparam int CW = ((AW > ReqW) ? AW : ReqW) + 1;
  localparam int MW = 2 + AW + AW;
  localparam logic [CW-1:0] HDR  = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] HEAP = CW'(HEAP_BYTES);

  logic [MW-1:0] mem [HEAP_BYTES];
  logic [MW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  logic            op;
  logic [ReqW-1:0] req;
  logic [OffW-1:0] off;
  logic [AW-1:0]   head_ptr;
  logic            head_nul;
  logic            ready;
  logic [AW-1:0]   cur_ptr;
  logic            cur_nul;
  logic [AW-1:0]   prev_ptr;
  logic            prev_nul;
  logic [AW-1:0]   prev_size;

  logic [1:0]    rd_tag;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] rd_size;
  logic [CW-1:0] size_x;
  logic [CW-1:0] req_x;
  logic [CW-1:0] rem_x;
  logic [CW-1:0] tail_x;
  logic [CW-1:0] h_x;
  logic [CW-1:0] ofs_x;
  logic [AW-1:0] tail_ptr;
  logic [AW-1:0] h_ptr;
  logic [1:0]    repl_tag;
  logic [AW-1:0] repl_ptr;

  assign rd_tag   = rd_q[MW-1 -: 2];
  assign rd_ptr   = rd_q[2*AW-1 -: AW];
  assign rd_size  = rd_q[AW-1:0];
  assign size_x   = CW'(rd_size);
  assign req_x    = CW'(req);
  assign rem_x    = size_x - req_x;
  assign tail_x   = CW'(cur_ptr) + HDR + req_x;
  assign tail_ptr = tail_x[AW-1:0];
  assign h_x      = CW'(off) - HDR;
  assign h_ptr    = h_x[AW-1:0];
  assign ofs_x    = CW'(cur_ptr) + HDR;

  always_comb begin
    if (rem_x > HDR) begin
      repl_tag = TAG_PTR;
      repl_ptr = tail_ptr;
    end else begin
      repl_tag = rd_tag;
      repl_ptr = rd_ptr;
    end
  end

  assign stat.is_alloc   = (op == OP_ALLOC);
  assign stat.req_zero   = (req == '0);
  assign stat.heap_ready = ready;
  assign stat.cur_null   = cur_nul;
  assign stat.fits       = (size_x >= req_x);
  assign stat.split      = (rem_x > HDR);
  assign stat.free_null  = (off == '0);
  assign stat.free_bad   = (CW'(off) < HDR) || (h_x >= HEAP);
  assign stat.free_used  = (rd_tag == TAG_USED);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    if (cmd.setup) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = {TAG_NULL, AW'(0), AW'(HEAP - HDR)};
    end else if (cmd.wr_tail) begin
      mem_we = 1'b1;
      mem_wa = tail_ptr;
      mem_wd = {rd_tag, rd_ptr, AW'(rem_x - HDR)};
    end else if (cmd.wr_prev) begin
      mem_we = !prev_nul;
      mem_wa = prev_ptr;
      mem_wd = {repl_tag, repl_ptr, prev_size};
    end else if (cmd.wr_mark) begin
      mem_we = 1'b1;
      mem_wa = cur_ptr;
      mem_wd = {TAG_USED, AW'(0), (rem_x > HDR) ? AW'(req_x) : rd_size};
    end else if (cmd.wr_free) begin
      mem_we = 1'b1;
      mem_wa = h_ptr;
      mem_wd = {head_nul ? TAG_NULL : TAG_PTR, head_ptr, rd_size};
    end
  end

  assign mem_re = cmd.rd_cur || cmd.rd_free;
  assign mem_ra = cmd.rd_free ? h_ptr : cur_ptr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_nul <= 1'b1;
      head_ptr <= '0;
      ready    <= 1'b0;
    end else begin
      if (cmd.setup) begin
        head_nul <= 1'b0;
        head_ptr <= '0;
        ready    <= 1'b1;
      end else if (cmd.wr_prev && prev_nul) begin
        head_nul <= (repl_tag != TAG_PTR);
        head_ptr <= repl_ptr;
      end else if (cmd.wr_free) begin
        head_nul <= 1'b0;
        head_ptr <= h_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= in_data[0];
      req      <= in_data[ReqW:1];
      off      <= in_data[ReqW+OffW:ReqW+1];
      cur_ptr  <= head_ptr;
      cur_nul  <= head_nul;
      prev_nul <= 1'b1;
    end else if (cmd.setup) begin
      cur_ptr <= '0;
      cur_nul <= 1'b0;
    end else if (cmd.step) begin
      prev_ptr  <= cur_ptr;
      prev_nul  <= 1'b0;
      prev_size <= rd_size;
      cur_ptr   <= rd_ptr;
      cur_nul   <= (rd_tag != TAG_PTR);
    end
    if (cmd.out_load) begin
      result_offset <= cmd.out_ofs ? ofs_x[OffW-1:0] : '0;
    end
  end

endmodule

[rtl/ffa_ctrl.sv]
// sequencer for allocate walks and frees
module ffa_ctrl import ffa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output status_t   status,
  output ffa_cmd_t  cmd,
  input  ffa_stat_t stat
);

  typedef enum logic [3:0] {
    IDLE, DECODE, SETUP, READ, EVAL, LINK, MARK, FEVAL, RESP
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t code;
  status_t code_next;
  logic    ofs;
  logic    ofs_next;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    code_next  = code;
    ofs_next   = ofs;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        ofs_next   = 1'b0;
        state_next = RESP;
        if (stat.is_alloc) begin
          if (stat.req_zero) begin
            code_next = ST_ZERO;
          end else if (!stat.heap_ready) begin
            state_next = SETUP;
          end else begin
            state_next = READ;
          end
        end else if (stat.free_null) begin
          code_next = ST_OK;
        end else if (stat.free_bad) begin
          code_next = ST_BADFREE;
        end else begin
          cmd.rd_free = 1'b1;
          state_next  = FEVAL;
        end
      end
      SETUP: begin
        cmd.setup  = 1'b1;
        state_next = READ;
      end
      READ: begin
        if (stat.cur_null) begin
          code_next  = ST_NOMEM;
          state_next = RESP;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = EVAL;
        end
      end
      EVAL: begin
        if (!stat.fits) begin
          cmd.step   = 1'b1;
          state_next = READ;
        end else begin
          cmd.wr_tail = stat.split;
          state_next  = LINK;
        end
      end
      LINK: begin
        cmd.wr_prev = 1'b1;
        state_next  = MARK;
      end
      MARK: begin
        cmd.wr_mark = 1'b1;
        code_next   = ST_OK;
        ofs_next    = 1'b1;
        state_next  = RESP;
      end
      FEVAL: begin
        state_next = RESP;
        if (stat.free_used) begin
          cmd.wr_free = 1'b1;
          code_next   = ST_OK;
        end else begin
          code_next = ST_BADFREE;
        end
      end
      RESP: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          cmd.out_ofs  = ofs;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      code     <= ST_OK;
      ofs      <= 1'b0;
      m_tvalid <= 1'b0;
      status   <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
      ofs   <= ofs_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
        status   <= code;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/first_fit_free_list_allocator_core.sv]
// top level of the first-fit free-list allocator
// First-fit heap allocator. Each input beat is an allocate or a free and gives
// exactly one result beat. A zero-size allocate, a null free and a free with a
// bad offset are answered without a memory read; any other free first reads its
// block header from the header memory. An allocate walks the free list from its
// head, one read of the header memory per entry visited, up to the first entry
// that fits, or to the end of the list when none fits; on a fit it then writes the
// tail header if the block is split, relinks the previous entry and marks the
// block used. The very first nonzero allocate first sets up the whole heap as a
// single free block. The input is ready again in the cycle after the result is
// loaded. Items are handled one at a time; a finished result waits in the output
// register while the next beat is taken. Freed blocks are not merged.
module first_fit_free_list_allocator_core import ffa_pkg::*; #(
  parameter int HEAP_BYTES   = 1048576,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // opcode, request_bytes, payload_offset
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // status, result_offset
);

  ffa_cmd_t        cmd;
  ffa_stat_t       stat;
  status_t         status;
  logic [OffW-1:0] result_offset;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd),
    .stat     (stat)
  );

  ffa_datapath #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_data       (s_tdata),
    .result_offset (result_offset)
  );

  assign m_tdata = {2'b00, result_offset, status};

endmodule

[tb/sv/first_fit_free_list_allocator_core_tb.sv]
// testbench for the first-fit free-list allocator: scoreboard with heap predictor, random traffic
module first_fit_free_list_allocator_core_tb;
  import ffa_pkg::*;

  localparam int unsigned HEAP = 1048576;
  localparam int unsigned HDR = 16;
  localparam logic [31:0] LINK_NONE = 32'hFFFF_FFFF;
  localparam logic [31:0] LINK_TAKEN = 32'hbaad_f00d;
  localparam logic OP_FREE = 1'b1;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [47:0] s_tdata;  // opcode, request_bytes, payload_offset
  logic m_tvalid;
  logic m_tready;
  logic [23:0] m_tdata;  // status, result_offset

  int errors = 0;
  int send_idle = 35;
  int recv_idle = 79;
  int hold_cycles = 0;

  first_fit_free_list_allocator_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  task automatic report(string msg);
    $display("error: %s", msg);
    errors++;
  endtask

  class heap_scoreboard;
    logic [31:0] hdr_link[int unsigned];
    logic [31:0] hdr_size[int unsigned];
    int unsigned written_q[$];
    int unsigned live_q[$];
    logic [31:0] head;
    bit ready;
    status_t want_status[$];
    logic [OffW-1:0] want_offset[$];

    function new();
      head = LINK_NONE;
      ready = 0;
    endfunction

    function logic [31:0] link_of(int unsigned h);
      return hdr_link.exists(h) ? hdr_link[h] : 32'd0;
    endfunction

    function logic [31:0] size_of(int unsigned h);
      return hdr_size.exists(h) ? hdr_size[h] : 32'd0;
    endfunction

    function void put(int unsigned h, logic [31:0] lnk, logic [31:0] sz);
      if (!hdr_link.exists(h)) written_q.push_back(h);
      hdr_link[h] = lnk;
      hdr_size[h] = sz;
    endfunction

    function void note(logic op, int unsigned req, int unsigned off);
      status_t st;
      int unsigned ro;
      logic [31:0] prev, cur, repl, tail;
      int unsigned guard;
      st = ST_OK;
      ro = 0;
      prev = LINK_NONE;
      guard = 0;
      if (op == OP_ALLOC) begin
        if (req == 0) begin
          st = ST_ZERO;
        end else begin
          if (!ready) begin
            put(0, LINK_NONE, HEAP - HDR);
            head = 0;
            ready = 1;
          end
          cur = head;
          while (cur < HEAP && size_of(cur) < req && guard < HEAP) begin
            prev = cur;
            cur = link_of(cur);
            guard++;
          end
          if (!(cur < HEAP) || size_of(cur) < req) begin
            st = ST_NOMEM;
          end else begin
            if (size_of(cur) - req <= HDR) begin
              repl = link_of(cur);
            end else begin
              tail = cur + HDR + req;
              put(tail, link_of(cur), size_of(cur) - req - HDR);
              hdr_size[cur] = req;
              repl = tail;
            end
            if (prev < HEAP) hdr_link[prev] = repl;
            else head = repl;
            hdr_link[cur] = LINK_TAKEN;
            ro = (cur + HDR) & 32'hFFFFF;
            live_q.push_back(ro);
          end
        end
      end else if (off != 0) begin
        if (off < HDR || !((off - HDR) < HEAP) || link_of(off - HDR) != LINK_TAKEN) begin
          st = ST_BADFREE;
        end else begin
          hdr_link[off - HDR] = head;
          head = off - HDR;
          foreach (live_q[i]) if (live_q[i] == off) begin
            live_q.delete(i);
            break;
          end
        end
      end
      want_status.push_back(st);
      want_offset.push_back(ro[OffW-1:0]);
    endfunction

    task check(logic [23:0] beat);
      status_t st;
      logic [OffW-1:0] ro;
      if (want_status.size() == 0) begin
        report($sformatf("unexpected result beat %h", beat));
        return;
      end
      st = want_status.pop_front();
      ro = want_offset.pop_front();
      if (beat[1:0] != st)
        report($sformatf("status %0d, expected %0d", beat[1:0], st));
      if (beat[21:2] != ro)
        report($sformatf("result_offset %h, expected %h", beat[21:2], ro));
    endtask
  endclass

  heap_scoreboard sb = new();

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic send(logic op, int unsigned req, int unsigned off);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1;
    s_tdata <= {6'd0, off[OffW-1:0], req[ReqW-1:0], op};
    do @(posedge clk); while (!s_tready);
    sb.note(op, req, off);
  endtask

  task automatic drain();
    int n;
    s_tvalid <= 0;
    n = 0;
    while (sb.want_status.size() != 0 && n < 2000000) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned r;
    int unsigned h;
    r = $urandom_range(99);
    if (r < 45 || sb.live_q.size() == 0) begin
      if ($urandom_range(19) == 0) send(OP_ALLOC, 0, $urandom_range(HEAP - 1));
      else if ($urandom_range(19) == 0) send(OP_ALLOC, $urandom_range(HEAP, 1), 0);
      else send(OP_ALLOC, $urandom_range(2048, 1), $urandom_range(HEAP - 1));
    end else if (r < 90) begin
      send(OP_FREE, $urandom_range(HEAP), sb.live_q[$urandom_range(sb.live_q.size() - 1)]);
    end else if (r < 93) begin
      send(OP_FREE, $urandom_range(HEAP), 0);
    end else if (r < 96) begin
      send(OP_FREE, 0, $urandom_range(HDR - 1, 1));
    end else if (sb.written_q.size() != 0) begin
      h = sb.written_q[$urandom_range(sb.written_q.size() - 1)];
      if (h + HDR < HEAP) send(OP_FREE, 0, h + HDR);
    end
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed part
    send(OP_ALLOC, 0, 0);
    send(OP_FREE, 0, 0);
    send(OP_FREE, HEAP, 1);
    send(OP_FREE, 0, HDR - 1);
    send(OP_ALLOC, HEAP, 20'hFFFFF);
    send(OP_ALLOC, 600000, 0);
    send(OP_ALLOC, 1000, 0);
    send(OP_FREE, 0, 600032);
    send(OP_FREE, 0, 600032);
    send(OP_FREE, 0, HDR);
    send(OP_ALLOC, 1000, 0);
    send(OP_ALLOC, HEAP - HDR, 0);
    send(OP_FREE, 0, HDR);
    send(OP_ALLOC, 599984, 0);
    send(OP_ALLOC, 1, 0);
    send(OP_ALLOC, 448528 - 1000 - 2 * HDR, 0);
    send(OP_ALLOC, 0, 0);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 35 : (ph == 1) ? 79 : 0;
      recv_idle = (ph == 0) ? 79 : (ph == 1) ? 35 : 0;
      if (ph == 2) hold_cycles = 400;
      repeat (660) random_item();
      drain();
    end
    if (sb.want_status.size() != 0)
      report($sformatf("%0d result beats missing", sb.want_status.size()));
    if (errors == 0) begin
      $display("first_fit_free_list_allocator_core: match");
    end else begin
      $display("first_fit_free_list_allocator_core: mismatch");
    end
    $finish;
  end

  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check(m_tdata);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    #1000000000;
    $display("first_fit_free_list_allocator_core: mismatch");
    $finish;
  end

endmodule

[files.f]
rtl/ffa_pkg.sv
rtl/ffa_datapath.sv
rtl/ffa_ctrl.sv
rtl/first_fit_free_list_allocator_core.sv
tb/sv/first_fit_free_list_allocator_core_tb.sv
